// ===== rtl/trqm_pkg.sv =====
// Package for the traffic rate and quota monitor.
// Field widths, arithmetic constants, register indexes and sequencer state codes.
// No dependencies.
package trqm_pkg;

	localparam int SecW   = 32;
	localparam int UsecW  = 20;
	localparam int BytesW = 32;
	localparam int RateW  = 32;
	localparam int KbW    = 32;
	localparam int QuotaW = 22;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 22;

	// elapsed microseconds as a signed value, and the bytes * 1e6 product
	localparam int ElapW = 54;
	localparam int ProdW = 52;
	localparam int MulAW = 33;
	localparam int KbShift = 10;

	localparam logic signed [20:0] MicrosPerSec = 21'sd1000000;

	localparam logic [CfgIdxW-1:0] REG_QUOTA_MB     = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_AUTO_CUT_OFF = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ALARM_ENABLE = 2'd2;

	typedef logic [2:0] state_t;
	localparam state_t ST_IDLE  = 3'd0;
	localparam state_t ST_PROD  = 3'd1;
	localparam state_t ST_ELAP  = 3'd2;
	localparam state_t ST_ADD   = 3'd3;
	localparam state_t ST_CHECK = 3'd4;
	localparam state_t ST_DIV   = 3'd5;
	localparam state_t ST_OUT   = 3'd6;

endpackage

// ===== rtl/traffic_rate_quota_monitor.sv =====
// Traffic rate and quota monitor: rate, peak, kilobyte total and one-shot quota alarm.
// Uses trqm_pkg. One shared constant multiplier and a radix-2 restoring divider.
//
// Usage:
//   A sample request comes in on in_valid/in_ready (timestamp, byte count, online flag).
//   One result request leaves on out_valid/out_ready with the rate, the peak, the total,
//   the alarm and cut-off flags and the interval fault flag.
//   in_ready is high only while the sequencer is idle. A sample passes through the
//   shared multiplier (ST_PROD, ST_ELAP), the adder (ST_ADD) and the range check
//   (ST_CHECK), then through the divider when the rate neither faults nor saturates,
//   and ST_OUT loads the output register. The divider gives one quotient bit per cycle.
//   A new sample is accepted only after ST_OUT has handed its result over.
//   The output register holds the last result while the next sample is worked on; if
//   the receiver still has not taken it when the next result is ready, the sequencer
//   waits in its last state and in_ready stays low.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once and are
//   meant for idle periods; a write to alarm_enable rearms the one-shot alarm.
//   Reset (arst_n low) clears the history, peak and total, sets alarm_enable and arms
//   the alarm; the first sample afterwards reports an interval fault with rate 0.
module traffic_rate_quota_monitor
	import trqm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SecW-1:0]     stamp_seconds,
	input  logic [UsecW-1:0]    stamp_micros,
	input  logic [BytesW-1:0]   interval_bytes,
	input  logic                link_online,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [RateW-1:0]    rate_bps,
	output logic [RateW-1:0]    peak_bps,
	output logic [KbW-1:0]      total_kb,
	output logic                quota_hit,
	output logic                cut_off_request,
	output logic                interval_fault
);

	// configuration
	logic [QuotaW-1:0] quota_mb_q;
	logic              auto_cut_off_q;
	logic              alarm_enable_q;

	// persistent state
	logic [SecW-1:0]   last_seconds_q;
	logic [UsecW-1:0]  last_micros_q;
	logic              have_last_q;
	logic [RateW-1:0]  peak_q;
	logic [KbW-1:0]    total_q;
	logic              alarm_armed_q;

	// per-sample working registers
	state_t                  state_q;
	logic signed [MulAW-1:0] dsec_q;
	logic signed [UsecW:0]   udiff_q;
	logic [BytesW-1:0]       bytes_q;
	logic                    online_q;
	logic                    have_q;
	logic                    fire_q;
	logic                    fault_q;
	logic signed [ElapW-1:0] mul_q;
	logic [ProdW-1:0]        prod_q;
	logic signed [ElapW-1:0] elapsed_q;
	logic [ElapW-2:0]        rem_q;
	logic [31:0]             lo_q;
	logic [RateW-1:0]        quo_q;
	logic [4:0]              cnt_q;

	// output register
	logic             out_valid_q;
	logic [RateW-1:0] rate_out_q;
	logic [RateW-1:0] peak_out_q;
	logic [KbW-1:0]   total_out_q;
	logic             hit_out_q;
	logic             cut_out_q;
	logic             fault_out_q;

	logic                    in_acc;
	logic                    out_free;
	logic signed [MulAW-1:0] mul_a;
	logic signed [ElapW-1:0] mul_p;
	logic [KbW:0]            kb_sum;
	logic [KbW-1:0]          quota_kb;
	logic [ElapW-2:0]        divisor;
	logic [ElapW-1:0]        trial;
	logic [ElapW-1:0]        trial_diff;
	logic                    trial_ge;
	logic                    elap_pos;
	logic                    rate_sat;
	logic [RateW-1:0]        peak_next;

	function automatic logic fire_q_next(input logic online, input logic enable,
		input logic armed, input logic [KbW-1:0] total, input logic [KbW-1:0] thresh);
		return online && enable && armed && (total >= thresh);
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// shared constant multiplier: bytes in ST_PROD, whole-second difference in ST_ELAP
	assign mul_a = (state_q == ST_PROD) ? $signed({1'b0, bytes_q}) : dsec_q;
	assign mul_p = ElapW'(mul_a) * ElapW'(MicrosPerSec);

	assign kb_sum   = {1'b0, total_q} + (KbW+1)'(interval_bytes >> KbShift);
	assign quota_kb = {quota_mb_q, {KbShift{1'b0}}};

	assign divisor    = elapsed_q[ElapW-2:0];
	assign elap_pos   = have_q && !elapsed_q[ElapW-1] && (|elapsed_q);
	// quotient overflows 32 bits when prod >= elapsed * 2^32
	assign rate_sat   = (divisor <= (ElapW-1)'(prod_q[ProdW-1:32]));
	assign trial      = {rem_q, lo_q[31]};
	assign trial_ge   = (trial >= {1'b0, divisor});
	assign trial_diff = trial - {1'b0, divisor};

	assign peak_next = (quo_q > peak_q) ? quo_q : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_mb_q     <= '0;
			auto_cut_off_q <= 1'b0;
			alarm_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_QUOTA_MB:     quota_mb_q     <= cfg_data[QuotaW-1:0];
				REG_AUTO_CUT_OFF: auto_cut_off_q <= cfg_data[0];
				REG_ALARM_ENABLE: alarm_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			last_seconds_q <= '0;
			last_micros_q  <= '0;
			have_last_q    <= 1'b0;
			peak_q         <= '0;
			total_q        <= '0;
			alarm_armed_q  <= 1'b1;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_seconds_q <= stamp_seconds;
						last_micros_q  <= stamp_micros;
						have_last_q    <= 1'b1;
						total_q        <= kb_sum[KbW] ? '1 : kb_sum[KbW-1:0];
						state_q        <= ST_PROD;
					end
				end
				ST_PROD: begin
					if (fire_q_next(online_q, alarm_enable_q, alarm_armed_q, total_q, quota_kb))
						alarm_armed_q <= 1'b0;
					state_q <= ST_ELAP;
				end
				ST_ELAP:  state_q <= ST_ADD;
				ST_ADD:   state_q <= ST_CHECK;
				ST_CHECK: state_q <= (elap_pos && !rate_sat) ? ST_DIV : ST_OUT;
				ST_DIV: begin
					if (cnt_q == 5'd0)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						peak_q  <= peak_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// a write to alarm_enable rearms the alarm
			if (cfg_wr_en && cfg_index == REG_ALARM_ENABLE)
				alarm_armed_q <= 1'b1;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					dsec_q   <= $signed({1'b0, stamp_seconds}) - $signed({1'b0, last_seconds_q});
					udiff_q  <= $signed({1'b0, stamp_micros}) - $signed({1'b0, last_micros_q});
					bytes_q  <= interval_bytes;
					online_q <= link_online;
					have_q   <= have_last_q;
				end
			end
			ST_PROD: begin
				mul_q  <= mul_p;
				fire_q <= fire_q_next(online_q, alarm_enable_q, alarm_armed_q, total_q, quota_kb);
			end
			ST_ELAP: begin
				prod_q <= mul_q[ProdW-1:0];
				mul_q  <= mul_p;
			end
			ST_ADD: elapsed_q <= mul_q + ElapW'(udiff_q);
			ST_CHECK: begin
				fault_q <= !elap_pos;
				rem_q   <= (ElapW-1)'(prod_q[ProdW-1:32]);
				lo_q    <= prod_q[31:0];
				cnt_q   <= 5'd31;
				quo_q   <= !elap_pos ? '0 : (rate_sat ? '1 : '0);
			end
			ST_DIV: begin
				rem_q <= trial_ge ? trial_diff[ElapW-2:0] : trial[ElapW-2:0];
				quo_q <= {quo_q[RateW-2:0], trial_ge};
				lo_q  <= {lo_q[30:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
			end
			ST_OUT: begin
				if (out_free) begin
					rate_out_q  <= quo_q;
					peak_out_q  <= peak_next;
					total_out_q <= total_q;
					hit_out_q   <= fire_q;
					cut_out_q   <= fire_q && auto_cut_off_q;
					fault_out_q <= fault_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign rate_bps        = rate_out_q;
	assign peak_bps        = peak_out_q;
	assign total_kb        = total_out_q;
	assign quota_hit       = hit_out_q;
	assign cut_off_request = cut_out_q;
	assign interval_fault  = fault_out_q;

endmodule
